// ===== rtl/core/fasta_index_builder_macros.svh =====
// assertion macros shared by the index builder rtl
// no dependencies; included by the files that carry assertions
`ifndef FASTA_INDEX_BUILDER_MACROS_SVH
`define FASTA_INDEX_BUILDER_MACROS_SVH

// same-cycle implication, muted during reset
`define FIB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fasta index builder: assertion failed");

// next-cycle implication, muted during reset
`define FIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fasta index builder: assertion failed");

`endif

// ===== rtl/core/fib_pkg.sv =====
// shared types, constants and helpers for the fasta index builder
// no dependencies; imported by every module of the block
package fib_pkg;

   localparam int OFFSET_BITS_DEF = 40;
   localparam int FIELD_BITS      = 40;
   localparam int SEQ_OFF_BITS    = 41;

   // result payload without kind and final flag, padded to whole bytes
   localparam int RSP_DATA_BITS  = 6 * FIELD_BITS + SEQ_OFF_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_DATA_BITS;

   // result queue, depth a power of two
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_CNT_BITS-1:0] LVL_IDLE_MAX = RSP_CNT_BITS'(RSP_DEPTH - 2);
   localparam logic [RSP_CNT_BITS-1:0] LVL_BUSY_MAX = RSP_CNT_BITS'(RSP_DEPTH - 4);

   localparam logic [7:0] CH_NL   = 8'd10;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_PLUS = 8'h2b;
   localparam logic [7:0] CH_GT   = 8'h3e;
   localparam logic [7:0] CH_AT   = 8'h40;

   typedef enum logic [1:0] {
      CLS_SEQ     = 2'd0,
      CLS_COMMENT = 2'd1,
      CLS_PLUS    = 2'd2,
      CLS_HEADER  = 2'd3
   } line_class_type;

   typedef enum logic [1:0] {
      KIND_RECORD   = 2'd0,
      KIND_MISMATCH = 2'd1,
      KIND_EMPTY    = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type                kind;
      logic [FIELD_BITS-1:0]          name_start;
      logic [FIELD_BITS-1:0]          name_length;
      logic signed [SEQ_OFF_BITS-1:0] seq_offset;
      logic [FIELD_BITS-1:0]          seq_length;
      logic [FIELD_BITS-1:0]          line_bases;
      logic [FIELD_BITS-1:0]          line_bytes;
      logic [FIELD_BITS-1:0]          error_line;
      logic                           final_result;
   } result_type;

   // line class from the first byte of a line
   function automatic line_class_type classify_byte(input logic [7:0] b);
      line_class_type c;
      case (b)
         CH_SEMI: c = CLS_COMMENT;
         CH_PLUS: c = CLS_PLUS;
         CH_GT:   c = CLS_HEADER;
         CH_AT:   c = CLS_HEADER;
         default: c = CLS_SEQ;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/fib_parse.sv =====
// byte parser: input register, line and record state, result generation
// depends on fib_pkg and the assertion macro header
`include "fasta_index_builder_macros.svh"

module fib_parse #(
   parameter int OFFSET_BITS = fib_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   input  logic [fib_pkg::RSP_CNT_BITS-1:0]    fifo_level,
   output logic [1:0]                          push_count,
   output fib_pkg::result_type                 push_rsp0,
   output fib_pkg::result_type                 push_rsp1
);
   import fib_pkg::*;

   localparam int OB = OFFSET_BITS;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_eof_ff;

   logic [OB-1:0]  file_offset_ff, file_offset_in;
   logic [OB-1:0]  line_start_ff, line_start_in;
   logic [OB-1:0]  cur_len_ff, cur_len_in;
   logic [OB-1:0]  line_count_ff, line_count_in;
   line_class_type line_class_ff, line_class_in;
   logic           skip_next_ff, skip_next_in;
   logic [OB-1:0]  rec_name_start_ff, rec_name_start_in;
   logic [OB-1:0]  rec_name_len_ff, rec_name_len_in;
   logic           rec_seq_vld_ff, rec_seq_vld_in;
   logic [OB-1:0]  rec_seq_off_ff, rec_seq_off_in;
   logic [OB-1:0]  rec_seq_len_ff, rec_seq_len_in;
   logic [OB-1:0]  rec_line_bytes_ff, rec_line_bytes_in;
   logic           mismatch_ff, mismatch_in;
   logic           empty_ff, empty_in;
   logic           error_stop_ff, error_stop_in;

   logic            is_nl;
   logic [OB-1:0]   len;
   logic            fail;
   logic            do_reset;
   result_kind_type err_kind;
   result_type      flush_rsp;

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [OB-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic result_type make_rsp(
      input result_kind_type kind,
      input logic [OB-1:0]   nm_start,
      input logic [OB-1:0]   nm_len,
      input logic            seq_vld,
      input logic [OB-1:0]   seq_off,
      input logic [OB-1:0]   seq_len,
      input logic [OB-1:0]   lbytes,
      input logic [OB-1:0]   err_line,
      input logic            fin
   );
      result_type    r;
      logic [63:0]   w_off;
      logic [OB-1:0] bases;
      w_off = 64'(seq_off);
      bases = (lbytes != '0) ? lbytes - OB'(1) : '0;
      r.kind         = kind;
      r.name_start   = to_field(nm_start);
      r.name_length  = to_field(nm_len);
      r.seq_offset   = seq_vld ? w_off[SEQ_OFF_BITS-1:0] : '1;
      r.seq_length   = to_field(seq_len);
      r.line_bases   = to_field(bases);
      r.line_bytes   = to_field(lbytes);
      r.error_line   = to_field(err_line);
      r.final_result = fin;
      return r;
   endfunction

   // room for the two results one byte may cause, counting the byte in flight
   assign req_tready  = in_valid_ff ? (fifo_level <= LVL_BUSY_MAX)
                                    : (fifo_level <= LVL_IDLE_MAX);
   assign in_valid_in = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_valid_in) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   always_comb begin
      file_offset_in    = file_offset_ff;
      line_start_in     = line_start_ff;
      cur_len_in        = cur_len_ff;
      line_count_in     = line_count_ff;
      line_class_in     = line_class_ff;
      skip_next_in      = skip_next_ff;
      rec_name_start_in = rec_name_start_ff;
      rec_name_len_in   = rec_name_len_ff;
      rec_seq_vld_in    = rec_seq_vld_ff;
      rec_seq_off_in    = rec_seq_off_ff;
      rec_seq_len_in    = rec_seq_len_ff;
      rec_line_bytes_in = rec_line_bytes_ff;
      mismatch_in       = mismatch_ff;
      empty_in          = empty_ff;
      error_stop_in     = error_stop_ff;
      push_count        = 2'd0;
      push_rsp0         = '0;
      push_rsp1         = '0;
      fail              = 1'b0;
      do_reset          = 1'b0;
      err_kind          = KIND_MISMATCH;
      is_nl             = (in_byte_ff == CH_NL);
      len               = cur_len_ff;
      flush_rsp         = '0;

      if (in_valid_ff) begin
         if (error_stop_ff) begin
            // drop bytes until end of file
            do_reset = in_eof_ff;
         end else begin
            if (!is_nl) begin
               if (cur_len_ff == '0) begin
                  line_class_in = classify_byte(in_byte_ff);
               end
               cur_len_in = cur_len_ff + OB'(1);
            end
            file_offset_in = file_offset_ff + OB'(1);
            len = cur_len_in;

            if (is_nl || in_eof_ff) begin
               line_count_in = line_count_ff + OB'(1);
               if (skip_next_ff) begin
                  skip_next_in = 1'b0;
               end else begin
                  case (line_class_in)
                     CLS_COMMENT: begin
                     end
                     CLS_PLUS: begin
                        skip_next_in = 1'b1;
                     end
                     CLS_HEADER: begin
                        if (rec_name_len_ff != '0) begin
                           mismatch_in = 1'b0;
                           empty_in    = 1'b0;
                           push_rsp0   = make_rsp(KIND_RECORD, rec_name_start_ff,
                                                  rec_name_len_ff, rec_seq_vld_ff,
                                                  rec_seq_off_ff, rec_seq_len_ff,
                                                  rec_line_bytes_ff, '0, 1'b0);
                           push_count  = 2'd1;
                           rec_seq_vld_in    = 1'b0;
                           rec_seq_off_in    = '0;
                           rec_seq_len_in    = '0;
                           rec_line_bytes_in = '0;
                        end
                        rec_name_start_in = line_start_ff + OB'(1);
                        rec_name_len_in   = len - OB'(1);
                     end
                     CLS_SEQ: begin
                        if (!rec_seq_vld_ff) begin
                           rec_seq_vld_in = 1'b1;
                           rec_seq_off_in = line_start_ff;
                        end
                        rec_seq_len_in = rec_seq_len_ff + len;
                        if (rec_line_bytes_ff != '0) begin
                           if ((mismatch_ff || empty_ff) && (len != '0)) begin
                              // a full line after a short or empty one
                              fail = 1'b1;
                              if (empty_ff) begin
                                 err_kind = KIND_EMPTY;
                              end
                              push_rsp0  = make_rsp(err_kind, rec_name_start_ff,
                                                    rec_name_len_ff, rec_seq_vld_in,
                                                    rec_seq_off_in, rec_seq_len_in,
                                                    rec_line_bytes_ff, line_count_in,
                                                    1'b1);
                              push_count = 2'd1;
                           end else begin
                              if ((mismatch_ff || empty_ff) && (len == '0)) begin
                                 empty_in = 1'b1;
                              end
                              if (rec_line_bytes_ff != len + OB'(1)) begin
                                 mismatch_in = 1'b1;
                                 if (len == '0) begin
                                    empty_in = 1'b1;
                                 end
                              end
                           end
                        end else begin
                           rec_line_bytes_in = len + OB'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
               end

               if (fail) begin
                  error_stop_in = 1'b1;
                  do_reset      = in_eof_ff;
               end else begin
                  cur_len_in    = '0;
                  line_class_in = CLS_SEQ;
                  line_start_in = file_offset_in;
               end
            end

            if (in_eof_ff && !fail) begin
               flush_rsp = make_rsp(KIND_RECORD, rec_name_start_in, rec_name_len_in,
                                    rec_seq_vld_in, rec_seq_off_in, rec_seq_len_in,
                                    rec_line_bytes_in, '0, 1'b1);
               if (push_count == 2'd1) begin
                  push_rsp1  = flush_rsp;
                  push_count = 2'd2;
               end else begin
                  push_rsp0  = flush_rsp;
                  push_count = 2'd1;
               end
               do_reset = 1'b1;
            end
         end
      end

      if (do_reset) begin
         file_offset_in    = '0;
         line_start_in     = '0;
         cur_len_in        = '0;
         line_count_in     = '0;
         line_class_in     = CLS_SEQ;
         skip_next_in      = 1'b0;
         rec_name_start_in = '0;
         rec_name_len_in   = '0;
         rec_seq_vld_in    = 1'b0;
         rec_seq_off_in    = '0;
         rec_seq_len_in    = '0;
         rec_line_bytes_in = '0;
         mismatch_in       = 1'b0;
         empty_in          = 1'b0;
         error_stop_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_offset_ff    <= '0;
         line_start_ff     <= '0;
         cur_len_ff        <= '0;
         line_count_ff     <= '0;
         line_class_ff     <= CLS_SEQ;
         skip_next_ff      <= 1'b0;
         rec_name_start_ff <= '0;
         rec_name_len_ff   <= '0;
         rec_seq_vld_ff    <= 1'b0;
         rec_seq_off_ff    <= '0;
         rec_seq_len_ff    <= '0;
         rec_line_bytes_ff <= '0;
         mismatch_ff       <= 1'b0;
         empty_ff          <= 1'b0;
         error_stop_ff     <= 1'b0;
      end else begin
         file_offset_ff    <= file_offset_in;
         line_start_ff     <= line_start_in;
         cur_len_ff        <= cur_len_in;
         line_count_ff     <= line_count_in;
         line_class_ff     <= line_class_in;
         skip_next_ff      <= skip_next_in;
         rec_name_start_ff <= rec_name_start_in;
         rec_name_len_ff   <= rec_name_len_in;
         rec_seq_vld_ff    <= rec_seq_vld_in;
         rec_seq_off_ff    <= rec_seq_off_in;
         rec_seq_len_ff    <= rec_seq_len_in;
         rec_line_bytes_ff <= rec_line_bytes_in;
         mismatch_ff       <= mismatch_in;
         empty_ff          <= empty_in;
         error_stop_ff     <= error_stop_in;
      end
   end

   `FIB_ASSERT_IMPL(a_quiet_after_error, clock, reset, error_stop_ff, push_count == 2'd0)
   `FIB_ASSERT_IMPL(a_pair_order, clock, reset, push_count == 2'd2, (push_rsp0.kind == KIND_RECORD) && !push_rsp0.final_result && push_rsp1.final_result)
   `FIB_ASSERT_IMPL(a_push_needs_byte, clock, reset, !in_valid_ff, push_count == 2'd0)
   `FIB_ASSERT_NEXT(a_eof_restarts, clock, reset, in_valid_ff && in_eof_ff, (file_offset_ff == '0) && !error_stop_ff)

endmodule

// ===== rtl/core/fib_rsp_fifo.sv =====
// small result queue, takes up to two results per cycle, gives one
// depends on fib_pkg and the assertion macro header
`include "fasta_index_builder_macros.svh"

module fib_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push_count,
   input  fib_pkg::result_type               push_rsp0,
   input  fib_pkg::result_type               push_rsp1,
   output logic [fib_pkg::RSP_CNT_BITS-1:0]  level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fib_pkg::result_type               rsp_head
);
   import fib_pkg::*;

   result_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_BITS-1:0] wr_ptr_nx;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic                    pop;

   assign pop       = (count_ff != '0) && rsp_ready;
   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(pop);
   assign count_in  = count_ff + RSP_CNT_BITS'(push_count) - RSP_CNT_BITS'(pop);

   assign level     = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_rsp0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push_rsp1;
      end
   end

   `FIB_ASSERT_IMPL(a_no_overflow, clock, reset, 1'b1, ({1'b0, count_ff} + {2'b00, push_count}) <= (RSP_CNT_BITS + 1)'(RSP_DEPTH))
   `FIB_ASSERT_IMPL(a_ptr_gap, clock, reset, 1'b1, RSP_PTR_BITS'(wr_ptr_ff - rd_ptr_ff) == RSP_PTR_BITS'(count_ff))
   `FIB_ASSERT_NEXT(a_pop_count, clock, reset, pop && (push_count == 2'd0), count_ff == RSP_CNT_BITS'($past(count_ff) - 1'b1))

endmodule

// ===== rtl/core/fasta_index_builder.sv =====
// top level of the fasta index builder: parser and result queue
// depends on fib_pkg, fib_parse and fib_rsp_fifo
//
// usage
// - request channel: one file byte per request, req_tlast marks the last
//   byte of a file; a newline ends a line, the last byte also ends one
// - response channel: one index record or error report per response,
//   rsp_tuser carries the kind, rsp_tlast the last response of the file
// - path: an accepted byte is held in the input register; the responses
//   it causes are written into the response queue and leave it one at a
//   time
// - throughput: one byte per cycle while the response queue is empty; a
//   byte causes at most two responses, which a four-entry queue absorbs;
//   whenever responses get queued the input pauses
// - stall: req_tready drops while the queue holds more than two responses,
//   or while a byte is in flight and the queue is not empty; bytes are
//   never lost
// - reset: synchronous, clears all counters, the pending record, the
//   error state and the response queue; no clearing pass
// - after the last response of a file (or the end of an errored file)
//   the block is back in its reset state for the next file
module fasta_index_builder #(
   parameter int OFFSET_BITS = fib_pkg::OFFSET_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] data_byte
   input  logic [7:0]                           req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // name_start, name_length, seq_offset, seq_length, line_bases,
   // line_bytes, error_line, then zero pad
   output logic [fib_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);
   import fib_pkg::*;

   // results travel from parser to queue, up to two per cycle
   logic [1:0]              push_count;
   result_type              push_rsp0;
   result_type              push_rsp1;
   logic [RSP_CNT_BITS-1:0] fifo_level;
   result_type              rsp_head;

   fib_parse #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_level (fifo_level),
      .push_count (push_count),
      .push_rsp0  (push_rsp0),
      .push_rsp1  (push_rsp1)
   );

   // response queue decouples the parser from a stalling receiver
   fib_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_rsp0  (push_rsp0),
      .push_rsp1  (push_rsp1),
      .level      (fifo_level),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_head   (rsp_head)
   );

   // pack the head response, first field in the low bits
   assign rsp_tdata = {RSP_PAD_BITS'(0),
                       rsp_head.error_line,
                       rsp_head.line_bytes,
                       rsp_head.line_bases,
                       rsp_head.seq_length,
                       rsp_head.seq_offset,
                       rsp_head.name_length,
                       rsp_head.name_start};
   assign rsp_tuser = rsp_head.kind;
   assign rsp_tlast = rsp_head.final_result;

endmodule

// ===== tb/fasta_index_builder_tb.sv =====
// self-checking bench for fasta_index_builder: streams fasta files byte by byte
// and checks every index record and error report against a local parser model
// depends on fib_pkg and the fasta_index_builder rtl
module fasta_index_builder_tb;
   import fib_pkg::*;

   localparam int OB = OFFSET_BITS_DEF;
   localparam int FB = FIELD_BITS;
   localparam int SB = SEQ_OFF_BITS;
   localparam logic [OB:0] SEQ_NONE = '1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 40;
   localparam int RANDOM_BYTES = 950;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain_first;
   } file_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   fasta_index_builder #(.OFFSET_BITS(OB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // file bytes waiting to be sent, and index records still to arrive
   file_byte_type pending_bytes[$];
   result_type expected_records[$];
   logic drain_next = 1'b0;

   // the progress counters move by nonblocking updates, the tallies by blocking ones
   int bytes_accepted = 0;
   int results_predicted = 0;
   int results_checked = 0;
   int cycle_no = 0;
   int quiet_cycles = 0;
   int entries_made = 0;
   int failures = 0;
   int files_made = 0;
   int records_seen = 0;
   int mismatch_reports = 0;
   int empty_reports = 0;

   // no random idling on either channel in this window
   wire steady = (cycle_no >= 300) && (cycle_no < 700);

   // ---------------------------------------------------------------
   // parser model: byte offset, line counters and the pending record
   // ---------------------------------------------------------------
   logic [OB-1:0] pos, line_begin, text_len, line_num;
   line_class_type cls;
   logic skip_line;
   logic [OB-1:0] hdr_start, hdr_len;
   logic [OB:0] first_seq;
   logic [OB-1:0] bases_total, width_bytes;
   logic width_bad, gap_seen, halted;

   function automatic void clear_entry();
      hdr_start = '0;
      hdr_len = '0;
      first_seq = SEQ_NONE;
      bases_total = '0;
      width_bytes = '0;
   endfunction

   function automatic void clear_parser();
      pos = '0;
      line_begin = '0;
      text_len = '0;
      line_num = '0;
      cls = CLS_SEQ;
      skip_line = 1'b0;
      clear_entry();
      width_bad = 1'b0;
      gap_seen = 1'b0;
      halted = 1'b0;
   endfunction

   function automatic void push_entry(input result_kind_type kind,
                                      input logic [OB-1:0] err_line,
                                      input logic fin);
      result_type r;
      r.kind = kind;
      r.name_start = hdr_start;
      r.name_length = hdr_len;
      r.seq_offset = first_seq;
      r.seq_length = bases_total;
      r.line_bases = (width_bytes != 0) ? width_bytes - 1'b1 : '0;
      r.line_bytes = width_bytes;
      r.error_line = err_line;
      r.final_result = fin;
      expected_records.insert(expected_records.size(), r);
      entries_made++;
   endfunction

   // a line has ended; returns 1 when it raises an error
   function automatic bit end_of_line();
      logic [OB-1:0] len;
      logic [OB-1:0] len_nl;
      len = text_len;
      len_nl = len + 1'b1;
      if (skip_line) begin
         // the quality line after a plus line
         skip_line = 1'b0;
         return 1'b0;
      end
      if (cls == CLS_COMMENT) return 1'b0;
      if (cls == CLS_PLUS) begin
         skip_line = 1'b1;
         return 1'b0;
      end
      if (cls == CLS_HEADER) begin
         // a nameless pending record is kept, only its name moves
         if (hdr_len != 0) begin
            width_bad = 1'b0;
            gap_seen = 1'b0;
            push_entry(KIND_RECORD, '0, 1'b0);
            clear_entry();
         end
         hdr_start = line_begin + 1'b1;
         hdr_len = len - 1'b1;
         return 1'b0;
      end
      if (first_seq == SEQ_NONE) first_seq = {1'b0, line_begin};
      bases_total = bases_total + len;
      if (width_bytes != 0) begin
         if (width_bad || gap_seen) begin
            if (len == 0) begin
               gap_seen = 1'b1;
            end else begin
               push_entry(gap_seen ? KIND_EMPTY : KIND_MISMATCH, line_num, 1'b1);
               return 1'b1;
            end
         end
         if (width_bytes != len_nl) begin
            width_bad = 1'b1;
            if (len == 0) gap_seen = 1'b1;
         end
      end else begin
         width_bytes = len_nl;
      end
      return 1'b0;
   endfunction

   // one accepted file byte
   function automatic void index_byte(input logic [7:0] b, input logic eof);
      logic nl;
      nl = (b == CH_NL);
      if (halted) begin
         // after an error only the end of file matters
         if (eof) clear_parser();
         return;
      end
      if (!nl) begin
         if (text_len == 0) begin
            if (b == CH_SEMI) cls = CLS_COMMENT;
            else if (b == CH_PLUS) cls = CLS_PLUS;
            else if (b == CH_GT || b == CH_AT) cls = CLS_HEADER;
            else cls = CLS_SEQ;
         end
         text_len = text_len + 1'b1;
      end
      pos = pos + 1'b1;
      if (nl || eof) begin
         line_num = line_num + 1'b1;
         if (end_of_line()) begin
            halted = 1'b1;
            if (eof) clear_parser();
            return;
         end
         text_len = '0;
         cls = CLS_SEQ;
         line_begin = pos;
      end
      if (eof) begin
         // flush the pending record, named or not
         push_entry(KIND_RECORD, '0, 1'b1);
         clear_parser();
      end
   endfunction

   // ---------------------------------------------------------------
   // file builders
   // ---------------------------------------------------------------
   function automatic void put_byte(input logic [7:0] b);
      file_byte_type item;
      item.data = b;
      item.last = 1'b0;
      item.drain_first = drain_next;
      drain_next = 1'b0;
      pending_bytes.insert(pending_bytes.size(), item);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   // mark the latest byte as the end of the file
   function automatic void end_file();
      file_byte_type item;
      item = pending_bytes.pop_back();
      item.last = 1'b1;
      pending_bytes.insert(pending_bytes.size(), item);
      files_made++;
   endfunction

   function automatic logic [7:0] any_but_newline();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_NL) b = 8'h0b;
      return b;
   endfunction

   function automatic logic [7:0] rand_base();
      string alphabet;
      alphabet = "ACGTNacgtn";
      if ($urandom_range(15) == 0) return any_but_newline();
      return alphabet[$urandom_range(9)];
   endfunction

   function automatic void seq_line(input int len);
      for (int i = 0; i < len; i++) put_byte(rand_base());
      put_byte(CH_NL);
   endfunction

   function automatic void skipped_lines();
      int n;
      n = $urandom_range(4);
      if ($urandom_range(1) == 0) begin
         put_byte(CH_SEMI);
         for (int i = 0; i < n; i++) put_byte(any_but_newline());
         put_byte(CH_NL);
      end else begin
         // plus line, then a quality line that may look like anything
         put_byte(CH_PLUS);
         for (int i = 0; i < n; i++) put_byte(any_but_newline());
         put_byte(CH_NL);
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) put_byte(any_but_newline());
         put_byte(CH_NL);
      end
   endfunction

   function automatic void make_random_file();
      int first, recs, width, lines, bad_line, len, name_len;
      first = pending_bytes.size();
      if ($urandom_range(24) == 0) begin
         // single-byte file
         put_byte(8'($urandom_range(255)));
         end_file();
         return;
      end
      recs = $urandom_range(3);
      if ($urandom_range(5) == 0) skipped_lines();
      if ($urandom_range(7) == 0) begin
         // sequence ahead of any header
         width = $urandom_range(1, 6);
         lines = $urandom_range(1, 3);
         for (int i = 0; i < lines; i++)
            seq_line(i == lines - 1 ? $urandom_range(1, width) : width);
      end
      for (int r = 0; r < recs; r++) begin
         put_byte($urandom_range(1) ? CH_GT : CH_AT);
         name_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < name_len; i++) put_byte(8'($urandom_range(33, 126)));
         put_byte(CH_NL);
         width = $urandom_range(1, 8);
         lines = $urandom_range(0, 4);
         bad_line = (lines > 1 && $urandom_range(7) == 0) ?
                    $urandom_range(0, lines - 2) : -1;
         for (int i = 0; i < lines; i++) begin
            if ($urandom_range(11) == 0) skipped_lines();
            len = (i == lines - 1) ? $urandom_range(1, width) : width;
            if (i == bad_line) len = $urandom_range(0, width + 2);
            seq_line(len);
         end
         if ($urandom_range(9) == 0) put_byte(CH_NL);
      end
      if ($urandom_range(11) == 0) begin
         // raw noise, newlines included
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
      end
      if (pending_bytes.size() == first || $urandom_range(1) == 0) begin
         // last line without a newline
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) put_byte(rand_base());
      end
      end_file();
   endfunction

   // ---------------------------------------------------------------
   // request driver: one file byte per request
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      file_byte_type head;
      logic taken, load;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) begin
            index_byte(req_tdata, req_tlast);
            bytes_accepted <= bytes_accepted + 1;
            results_predicted <= entries_made;
         end
         if (!req_tvalid || taken) begin
            load = (pending_bytes.size() != 0) && (steady || $urandom_range(99) >= 9);
            // marked bytes wait until every expected response is in
            if (load && pending_bytes[0].drain_first)
               load = !req_tvalid && (results_checked == results_predicted);
            if (load) begin
               head = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= head.data;
               req_tlast <= head.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor and checker
   // ---------------------------------------------------------------
   function automatic void compare_field(input string label, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked <= results_checked + 1;
            if (rsp_tlast) records_seen++;
            if (rsp_tuser == KIND_MISMATCH) mismatch_reports++;
            if (rsp_tuser == KIND_EMPTY) empty_reports++;
            if (expected_records.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: unexpected response, expected none, actual kind %0d data %0h",
                           $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_records.pop_front();
               compare_field("result_kind", 64'(want.kind), 64'(rsp_tuser));
               compare_field("name_start", 64'(want.name_start), 64'(rsp_tdata[0 +: FB]));
               compare_field("name_length", 64'(want.name_length), 64'(rsp_tdata[FB +: FB]));
               // field bits only, the -1 marker is compared as all ones
               compare_field("seq_offset", 64'(unsigned'(want.seq_offset)),
                             64'(rsp_tdata[2*FB +: SB]));
               compare_field("seq_length", 64'(want.seq_length),
                             64'(rsp_tdata[2*FB+SB +: FB]));
               compare_field("line_bases", 64'(want.line_bases),
                             64'(rsp_tdata[3*FB+SB +: FB]));
               compare_field("line_bytes", 64'(want.line_bytes),
                             64'(rsp_tdata[4*FB+SB +: FB]));
               compare_field("error_line", 64'(want.error_line),
                             64'(rsp_tdata[5*FB+SB +: FB]));
               compare_field("final_result", 64'(want.final_result), 64'(rsp_tlast));
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 9);
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long without any request or response moving
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d responses outstanding", $time,
                  quiet_cycles, results_predicted - results_checked);
         $display("[fasta_index_builder] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int total;
      int random_start;
      clear_parser();

      // header after a named record, last line without newline
      put_text(">a\nAC\n>b\nG");
      end_file();
      // comment, plus line with its quality line, empty-named header, byte 0
      put_text(";\n+\n");
      put_byte(8'hff);
      put_text("\n@\n");
      put_byte(8'h00);
      end_file();
      // empty line inside a sequence, then a byte that is ignored
      put_text("A\n\nA\nQ");
      end_file();
      // width change before the last line, error on the end-of-file byte
      put_text("AA\nA\nAA");
      end_file();

      // random files; some wait for the response queue to drain first
      drain_next = 1'b1;
      random_start = pending_bytes.size();
      while (pending_bytes.size() - random_start < RANDOM_BYTES) begin
         if (files_made % 12 == 0) drain_next = 1'b1;
         make_random_file();
      end
      total = pending_bytes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!(bytes_accepted == total && results_checked == results_predicted))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_records.size() != 0) begin
         failures++;
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_records.size());
      end

      $display("run covered %0d files in %0d bytes: %0d file ends, %0d width errors, %0d %s",
               files_made, total, records_seen, mismatch_reports, empty_reports,
               "gap errors");
      $display("%0d responses checked, %0d field failures", results_checked, failures);
      if (failures == 0) begin
         $display("[fasta_index_builder] OK");
      end else begin
         $display("[fasta_index_builder] ERROR");
      end
      $finish;
   end

endmodule
